@@ rtl/lft_pkg.sv @@
// Shared types, codes and byte decode functions for the logic formula tokenizer.
`default_nettype none

package lft_pkg;

   localparam logic [3:0] K_EOF    = 4'd0;
   localparam logic [3:0] K_BAD    = 4'd1;
   localparam logic [3:0] K_SEMI   = 4'd2;
   localparam logic [3:0] K_OPEN   = 4'd3;
   localparam logic [3:0] K_CLOSE  = 4'd4;
   localparam logic [3:0] K_TRUE   = 4'd5;
   localparam logic [3:0] K_FALSE  = 4'd6;
   localparam logic [3:0] K_VAR    = 4'd7;
   localparam logic [3:0] K_IMPL   = 4'd8;
   localparam logic [3:0] K_BICOND = 4'd9;
   localparam logic [3:0] K_AND    = 4'd10;
   localparam logic [3:0] K_OR     = 4'd11;
   localparam logic [3:0] K_XOR    = 4'd12;
   localparam logic [3:0] K_NOT    = 4'd13;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_OPEN  = 8'h28;
   localparam logic [7:0] CHAR_CLOSE = 8'h29;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_F     = 8'h66;

   localparam logic [7:0] BYTE_E2 = 8'hE2;
   localparam logic [7:0] BYTE_C2 = 8'hC2;
   localparam logic [7:0] BYTE_86 = 8'h86;
   localparam logic [7:0] BYTE_92 = 8'h92;
   localparam logic [7:0] BYTE_94 = 8'h94;
   localparam logic [7:0] BYTE_88 = 8'h88;
   localparam logic [7:0] BYTE_A7 = 8'hA7;
   localparam logic [7:0] BYTE_A8 = 8'hA8;
   localparam logic [7:0] BYTE_8A = 8'h8A;
   localparam logic [7:0] BYTE_BB = 8'hBB;
   localparam logic [7:0] BYTE_AC = 8'hAC;
   localparam logic [7:0] BYTE_HIGH_MASK = 8'h80;

   typedef struct packed {
      logic alpha;
      logic digit;
      logic space;
      logic under;
   } lft_class_type;

   typedef struct packed {
      logic lane0;
      logic lane1;
   } lft_wr_type;

   function automatic lft_class_type lft_classify(input logic [7:0] c);
      lft_class_type cls;
      cls.alpha = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
      cls.digit = c inside {[8'h30:8'h39]};
      cls.space = c inside {8'h20, [8'h09:8'h0D]};
      cls.under = (c == CHAR_UNDER);
      return cls;
   endfunction

   function automatic logic [7:0] lft_kw_letter(input logic is_t, input logic [2:0] p);
      logic [7:0] ch;
      case ({is_t, p})
         4'b1000: ch = 8'h74;
         4'b1001: ch = 8'h72;
         4'b1010: ch = 8'h75;
         4'b1011: ch = 8'h65;
         4'b0000: ch = 8'h66;
         4'b0001: ch = 8'h61;
         4'b0010: ch = 8'h6C;
         4'b0011: ch = 8'h73;
         4'b0100: ch = 8'h65;
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [3:0] lft_glyph_kind(input logic [7:0] second,
                                                 input logic [7:0] third);
      logic [3:0] k;
      k = K_BAD;
      if (second == BYTE_86 && third == BYTE_92) k = K_IMPL;
      else if (second == BYTE_86 && third == BYTE_94) k = K_BICOND;
      else if (second == BYTE_88 && third == BYTE_A7) k = K_AND;
      else if (second == BYTE_88 && third == BYTE_A8) k = K_OR;
      else if (second == BYTE_8A && third == BYTE_BB) k = K_XOR;
      return k;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lft_fifo.sv @@
// Small register queue with two write lanes and one read port.
`default_nettype none

module lft_fifo import lft_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lft_wr_type               wr,
   input  wire logic [WIDTH-1:0]         wr_data0,
   input  wire logic [WIDTH-1:0]         wr_data1,
   input  wire logic                     rd_en,
   output logic [WIDTH-1:0]              rd_data,
   output logic                          empty,
   output logic                          full,
   output logic [$clog2(DEPTH):0]        free
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_wr;
   logic             rd_go;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign free    = CNT_W'(DEPTH) - count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign rd_go   = rd_en && !empty;
   assign n_wr    = CNT_W'(wr.lane0) + CNT_W'(wr.lane1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_wr);
      rd_ptr_in = rd_ptr_ff + PTR_W'(rd_go);
      count_in  = count_ff + n_wr - CNT_W'(rd_go);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.lane0) begin
         mem_ff[wr_ptr_ff] <= wr_data0;
      end
      if (wr.lane1) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= wr_data1;
      end
   end

endmodule

`default_nettype wire

@@ rtl/lft_front.sv @@
// Front end: byte intake, character classing and position tracking.
`default_nettype none

module lft_front import lft_pkg::*; #(
   parameter int OFFSET_BITS = 32,
   parameter int ROW_BITS    = 24,
   parameter int COLUMN_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire logic                     full,
   input  wire logic [7:0]               in_byte,
   output lft_wr_type                    wr,
   output logic [8+4+2*(OFFSET_BITS+ROW_BITS+COLUMN_BITS)-1:0] wr_data
);

   localparam int POS_W = OFFSET_BITS + ROW_BITS + COLUMN_BITS;

   logic [POS_W-1:0]       cur_ff, cur_in;
   logic [POS_W-1:0]       prev_ff;
   logic [OFFSET_BITS-1:0] off, off_in;
   logic [ROW_BITS-1:0]    row, row_in;
   logic [COLUMN_BITS-1:0] col, col_in;
   lft_class_type          cls;
   logic                   accept;

   assign accept = push && !full;
   assign cls    = lft_classify(in_byte);
   assign off    = cur_ff[POS_W-1 -: OFFSET_BITS];
   assign row    = cur_ff[COLUMN_BITS +: ROW_BITS];
   assign col    = cur_ff[COLUMN_BITS-1:0];

   // advance with saturation
   always_comb begin
      off_in = (off != '1) ? off + 1'b1 : off;
      row_in = row;
      col_in = col;
      if (in_byte == CHAR_LF) begin
         col_in = COLUMN_BITS'(1);
         if (row != '1) begin
            row_in = row + 1'b1;
         end
      end else if ((in_byte & BYTE_HIGH_MASK) == CHAR_NUL && col != '1) begin
         col_in = col + 1'b1;
      end
      cur_in = {off_in, row_in, col_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= {OFFSET_BITS'(0), ROW_BITS'(1), COLUMN_BITS'(1)};
         prev_ff <= {OFFSET_BITS'(0), ROW_BITS'(1), COLUMN_BITS'(1)};
      end else if (accept) begin
         cur_ff  <= cur_in;
         prev_ff <= cur_ff;
      end
   end

   assign wr.lane0 = accept;
   assign wr.lane1 = 1'b0;
   assign wr_data  = {in_byte, cls, cur_ff, prev_ff};

endmodule

`default_nettype wire

@@ rtl/lft_back.sv @@
// Back end: token scanner that turns classed bytes into result tokens.
`default_nettype none

module lft_back import lft_pkg::*; #(
   parameter int OFFSET_BITS = 32,
   parameter int ROW_BITS    = 24,
   parameter int COLUMN_BITS = 16,
   parameter int FREE_W      = 3
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_empty,
   input  wire logic [8+4+2*(OFFSET_BITS+ROW_BITS+COLUMN_BITS)-1:0] in_data,
   output logic                          in_pop,
   input  wire logic [FREE_W-1:0]        out_free,
   output lft_wr_type                    out_wr,
   output logic [4+2*(OFFSET_BITS+ROW_BITS+COLUMN_BITS)+1-1:0] out_data0,
   output logic [4+2*(OFFSET_BITS+ROW_BITS+COLUMN_BITS)+1-1:0] out_data1,
   output logic                          halted
);

   localparam int POS_W   = OFFSET_BITS + ROW_BITS + COLUMN_BITS;
   localparam int ENTRY_W = 8 + 4 + 2 * POS_W;

   localparam logic [2:0] M_IDLE  = 3'd0;
   localparam logic [2:0] M_IDENT = 3'd1;
   localparam logic [2:0] M_TRUE  = 3'd2;
   localparam logic [2:0] M_FALSE = 3'd3;
   localparam logic [2:0] M_E2A   = 3'd4;
   localparam logic [2:0] M_E2B   = 3'd5;
   localparam logic [2:0] M_C2    = 3'd6;

   logic [2:0]       mode_ff, mode_in;
   logic [2:0]       kw_ff, kw_in;
   logic [7:0]       second_ff, second_in;
   logic [POS_W-1:0] start_ff, start_in;
   logic             halted_ff, halted_in;

   logic [7:0]       c;
   lft_class_type    cls;
   logic [POS_W-1:0] cur, prev;
   logic             alnum, word_ch, is_t;
   logic [2:0]       kw_len;
   logic [3:0]       gk;

   logic             id_emit, id_mark, id_halt;
   logic [3:0]       id_kind;
   logic [2:0]       id_mode, id_kw;

   logic             pend_emit, run_idle, bad_start, idle_emit, go, act;
   logic [3:0]       pend_kind;
   logic [POS_W-1:0] pend_end;

   assign c     = in_data[ENTRY_W-1 -: 8];
   assign cls   = lft_class_type'(in_data[ENTRY_W-9 -: 4]);
   assign cur   = in_data[2*POS_W-1 -: POS_W];
   assign prev  = in_data[POS_W-1:0];
   assign alnum   = cls.alpha || cls.digit;
   assign word_ch = alnum || cls.under;
   assign is_t    = (mode_ff == M_TRUE);
   assign kw_len  = is_t ? 3'd4 : 3'd5;
   assign gk      = lft_glyph_kind(second_ff, c);

   assign go     = !in_empty && (out_free >= FREE_W'(2));
   assign act    = go && !halted_ff;
   assign in_pop = go;
   assign halted = halted_ff;

   // byte seen between tokens
   always_comb begin
      id_emit = 1'b0;
      id_kind = K_EOF;
      id_mode = M_IDLE;
      id_kw   = 3'd0;
      id_mark = 1'b0;
      id_halt = 1'b0;
      if (c == CHAR_NUL) begin
         id_emit = 1'b1;
         id_kind = K_EOF;
         id_halt = 1'b1;
      end else if (cls.space) begin
         id_emit = 1'b0;
      end else if (c == CHAR_SEMI) begin
         id_emit = 1'b1;
         id_kind = K_SEMI;
      end else if (c == CHAR_OPEN) begin
         id_emit = 1'b1;
         id_kind = K_OPEN;
      end else if (c == CHAR_CLOSE) begin
         id_emit = 1'b1;
         id_kind = K_CLOSE;
      end else if (c == CHAR_T) begin
         id_mode = M_TRUE;
         id_kw   = 3'd1;
         id_mark = 1'b1;
      end else if (c == CHAR_F) begin
         id_mode = M_FALSE;
         id_kw   = 3'd1;
         id_mark = 1'b1;
      end else if (cls.alpha || cls.under) begin
         id_mode = M_IDENT;
         id_mark = 1'b1;
      end else if (c == BYTE_E2) begin
         id_mode = M_E2A;
         id_mark = 1'b1;
      end else if (c == BYTE_C2) begin
         id_mode = M_C2;
         id_mark = 1'b1;
      end else begin
         id_emit = 1'b1;
         id_kind = K_BAD;
         id_halt = 1'b1;
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      kw_in     = kw_ff;
      second_in = second_ff;
      start_in  = start_ff;
      halted_in = halted_ff;
      pend_emit = 1'b0;
      pend_kind = K_VAR;
      pend_end  = prev;
      run_idle  = 1'b0;
      bad_start = 1'b0;
      case (mode_ff)
         M_IDENT: begin
            if (!word_ch) begin
               pend_emit = 1'b1;
               run_idle  = 1'b1;
            end
         end
         M_TRUE, M_FALSE: begin
            if (kw_ff >= kw_len) begin
               if (alnum) begin
                  mode_in = M_IDENT;
                  kw_in   = 3'd0;
               end else begin
                  pend_emit = 1'b1;
                  pend_kind = is_t ? K_TRUE : K_FALSE;
                  run_idle  = 1'b1;
               end
            end else if (c == lft_kw_letter(is_t, kw_ff)) begin
               kw_in = kw_ff + 3'd1;
            end else if (word_ch) begin
               mode_in = M_IDENT;
               kw_in   = 3'd0;
            end else begin
               pend_emit = 1'b1;
               run_idle  = 1'b1;
            end
         end
         M_E2A: begin
            if (c inside {BYTE_86, BYTE_88, BYTE_8A}) begin
               second_in = c;
               mode_in   = M_E2B;
            end else begin
               bad_start = 1'b1;
            end
         end
         M_E2B: begin
            second_in = CHAR_NUL;
            if (gk == K_BAD) begin
               bad_start = 1'b1;
            end else begin
               pend_emit = 1'b1;
               pend_kind = gk;
               pend_end  = cur;
               mode_in   = M_IDLE;
            end
         end
         M_C2: begin
            if (c == BYTE_AC) begin
               pend_emit = 1'b1;
               pend_kind = K_NOT;
               pend_end  = cur;
               mode_in   = M_IDLE;
            end else begin
               bad_start = 1'b1;
            end
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase
      if (bad_start) begin
         pend_emit = 1'b1;
         pend_kind = K_BAD;
         pend_end  = start_ff;
         halted_in = 1'b1;
         mode_in   = M_IDLE;
      end
      if (run_idle) begin
         mode_in = id_mode;
         kw_in   = id_kw;
         if (id_mark) begin
            start_in = cur;
         end
         if (id_halt) begin
            halted_in = 1'b1;
         end
      end
   end

   assign idle_emit    = run_idle && id_emit;
   assign out_wr.lane0 = act && (pend_emit || idle_emit);
   assign out_wr.lane1 = act && pend_emit && idle_emit;
   assign out_data1    = {id_kind, cur, cur, 1'b1};
   assign out_data0    = pend_emit ? {pend_kind, start_ff, pend_end, !idle_emit}
                                   : out_data1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         kw_ff     <= 3'd0;
         halted_ff <= 1'b0;
      end else if (act) begin
         mode_ff   <= mode_in;
         kw_ff     <= kw_in;
         halted_ff <= halted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (act) begin
         second_ff <= second_in;
         start_ff  <= start_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/logic_formula_tokenizer_top.sv @@
// Top level of the logic formula tokenizer: front end, byte queue, scanner, result queue.
//
//   channel  | ports                             | direction | transfer when
//   ---------+-----------------------------------+-----------+------------------
//   bytes    | push, full, req_in_byte           | in        | push && !full
//   tokens   | empty, pop, rsp_*                 | out       | pop && !empty
//
// The scanner takes one byte a cycle from the byte queue, save while held as below.
// A byte gives 0, 1 or 2 tokens, written into the result queue together.
// A token enters the result queue when the scanner takes the byte that completes it.
// The scanner holds while the result queue has fewer than two free slots.
// Synchronous reset clears all control state; no clearing sweep is needed.
// After end of input or a bad token, later bytes are taken and dropped until reset.
`default_nettype none

module logic_formula_tokenizer_top import lft_pkg::*; #(
   parameter int OFFSET_BITS = 32,
   parameter int ROW_BITS    = 24,
   parameter int COLUMN_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_in_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [3:0]       rsp_token_kind,
   output logic [31:0]      rsp_begin_offset,
   output logic [31:0]      rsp_end_offset,
   output logic [23:0]      rsp_begin_row,
   output logic [15:0]      rsp_begin_column,
   output logic [23:0]      rsp_end_row,
   output logic [15:0]      rsp_end_column,
   output logic             rsp_last_of_run
);

   localparam int POS_W   = OFFSET_BITS + ROW_BITS + COLUMN_BITS;
   localparam int ENTRY_W = 8 + 4 + 2 * POS_W;
   localparam int TOK_W   = 4 + 2 * POS_W + 1;
   localparam int BQ_DEPTH = 4;
   localparam int RQ_DEPTH = 4;
   localparam int BQ_FREE_W = $clog2(BQ_DEPTH) + 1;
   localparam int RQ_FREE_W = $clog2(RQ_DEPTH) + 1;

   lft_wr_type             bq_wr;
   logic [ENTRY_W-1:0]     bq_wd, bq_rd;
   logic                   bq_empty, bq_pop;
   logic [BQ_FREE_W-1:0]   bq_free;

   lft_wr_type             rq_wr;
   logic [TOK_W-1:0]       rq_wd0, rq_wd1, rq_rd;
   logic                   rq_full;
   logic [RQ_FREE_W-1:0]   rq_free;
   logic                   bk_halted;

   logic [POS_W-1:0]       beg_pos, end_pos;

   lft_front #(
      .OFFSET_BITS(OFFSET_BITS),
      .ROW_BITS(ROW_BITS),
      .COLUMN_BITS(COLUMN_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .in_byte(req_in_byte),
      .wr(bq_wr),
      .wr_data(bq_wd)
   );

   lft_fifo #(
      .WIDTH(ENTRY_W),
      .DEPTH(BQ_DEPTH)
   ) u_byte_q (
      .clock(clock),
      .reset(reset),
      .wr(bq_wr),
      .wr_data0(bq_wd),
      .wr_data1(bq_wd),
      .rd_en(bq_pop),
      .rd_data(bq_rd),
      .empty(bq_empty),
      .full(full),
      .free(bq_free)
   );

   lft_back #(
      .OFFSET_BITS(OFFSET_BITS),
      .ROW_BITS(ROW_BITS),
      .COLUMN_BITS(COLUMN_BITS),
      .FREE_W(RQ_FREE_W)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .in_empty(bq_empty),
      .in_data(bq_rd),
      .in_pop(bq_pop),
      .out_free(rq_free),
      .out_wr(rq_wr),
      .out_data0(rq_wd0),
      .out_data1(rq_wd1),
      .halted(bk_halted)
   );

   lft_fifo #(
      .WIDTH(TOK_W),
      .DEPTH(RQ_DEPTH)
   ) u_result_q (
      .clock(clock),
      .reset(reset),
      .wr(rq_wr),
      .wr_data0(rq_wd0),
      .wr_data1(rq_wd1),
      .rd_en(pop),
      .rd_data(rq_rd),
      .empty(empty),
      .full(rq_full),
      .free(rq_free)
   );

   assign beg_pos = rq_rd[2*POS_W:POS_W+1];
   assign end_pos = rq_rd[POS_W:1];

   assign rsp_token_kind   = rq_rd[TOK_W-1 -: 4];
   assign rsp_begin_offset = 32'(beg_pos[POS_W-1 -: OFFSET_BITS]);
   assign rsp_begin_row    = 24'(beg_pos[COLUMN_BITS +: ROW_BITS]);
   assign rsp_begin_column = 16'(beg_pos[COLUMN_BITS-1:0]);
   assign rsp_end_offset   = 32'(end_pos[POS_W-1 -: OFFSET_BITS]);
   assign rsp_end_row      = 24'(end_pos[COLUMN_BITS +: ROW_BITS]);
   assign rsp_end_column   = 16'(end_pos[COLUMN_BITS-1:0]);
   assign rsp_last_of_run  = rq_rd[0];

   a_room_for_tokens: assert property (@(posedge clock) disable iff (reset)
      rq_wr.lane0 |-> (rq_free >= RQ_FREE_W'(2)) && !rq_full)
      else $error("token written without two free result slots");

   a_silent_when_halted: assert property (@(posedge clock) disable iff (reset)
      bk_halted |-> !rq_wr.lane0 && !rq_wr.lane1)
      else $error("token written after end of input");

   a_eof_halts: assert property (@(posedge clock) disable iff (reset)
      (rq_wr.lane0 && rq_wd0[TOK_W-1 -: 4] == K_EOF) |=> bk_halted)
      else $error("end of input did not stop the scanner");

   a_byte_queued: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> !bq_empty || (bq_free != '0 && $past(bq_pop)))
      else $error("accepted byte lost before the scanner");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench for logic_formula_tokenizer_top: byte stream in, tokens checked against a scanner model.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lft_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int REPORT_LIMIT = 10;
   localparam int HOLD_CYCLES = 500;
   localparam int LONG_LINE_SPACES = 100;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [47:0] BLANK_SET = {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
   localparam logic [23:0] PUNCT_SET = {CHAR_SEMI, CHAR_OPEN, CHAR_CLOSE};
   localparam logic [23:0] GLYPH_MID_SET = {BYTE_86, BYTE_88, BYTE_8A};
   localparam logic [31:0] TRUE_TEXT = "true";
   localparam logic [39:0] FALSE_TEXT = "false";

   typedef enum logic [2:0] {
      SCAN_GAP, SCAN_NAME, SCAN_TRUE, SCAN_FALSE, SCAN_E2, SCAN_E2_MID, SCAN_C2
   } scan_mode_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] begin_offset;
      logic [31:0] end_offset;
      logic [23:0] begin_row;
      logic [15:0] begin_column;
      logic [23:0] end_row;
      logic [15:0] end_column;
      logic        last;
   } token_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_in_byte = 8'h00;
   logic        empty;
   logic        pop = 1'b0;
   logic [3:0]  rsp_token_kind;
   logic [31:0] rsp_begin_offset;
   logic [31:0] rsp_end_offset;
   logic [23:0] rsp_begin_row;
   logic [15:0] rsp_begin_column;
   logic [23:0] rsp_end_row;
   logic [15:0] rsp_end_column;
   logic        rsp_last_of_run;

   logic_formula_tokenizer_top dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .empty            (empty),
      .pop              (pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_begin_offset (rsp_begin_offset),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_begin_row    (rsp_begin_row),
      .rsp_begin_column (rsp_begin_column),
      .rsp_end_row      (rsp_end_row),
      .rsp_end_column   (rsp_end_column),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   // scanner model state
   scan_mode_type mode = SCAN_GAP;
   int unsigned matched = 0;
   logic [7:0]  glyph_mid = 8'h00;
   logic [31:0] at_offset = 32'd0;
   logic [23:0] at_row = 24'd1;
   logic [15:0] at_column = 16'd1;
   logic [31:0] tok_offset = 32'd0;
   logic [23:0] tok_row = 24'd1;
   logic [15:0] tok_column = 16'd1;
   logic [31:0] prior_offset = 32'd0;
   logic [23:0] prior_row = 24'd1;
   logic [15:0] prior_column = 16'd1;
   bit          stopped = 1'b0;

   token_type step_tokens[$];
   token_type expected_tokens[$];

   bit tx_gaps = 1'b1;
   bit rx_gaps = 1'b1;
   bit hold_request = 1'b0;
   int bytes_sent = 0;
   int tokens_checked = 0;
   int mismatches = 0;
   int cycle_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic bit is_word(input logic [7:0] c);
      return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [7:0] keyword_char(input bit is_t, input int idx);
      return is_t ? TRUE_TEXT[8*(3-idx) +: 8] : FALSE_TEXT[8*(4-idx) +: 8];
   endfunction

   function automatic logic [3:0] glyph_code(input logic [7:0] mid, input logic [7:0] c);
      if (mid == BYTE_86 && c == BYTE_92) return K_IMPL;
      if (mid == BYTE_86 && c == BYTE_94) return K_BICOND;
      if (mid == BYTE_88 && c == BYTE_A7) return K_AND;
      if (mid == BYTE_88 && c == BYTE_A8) return K_OR;
      if (mid == BYTE_8A && c == BYTE_BB) return K_XOR;
      return K_BAD;
   endfunction

   function automatic string token_text(input token_type t);
      return $sformatf("kind %0d begin %0d/%0d:%0d end %0d/%0d:%0d last %0b",
                       t.kind, t.begin_offset, t.begin_row, t.begin_column,
                       t.end_offset, t.end_row, t.end_column, t.last);
   endfunction

   function automatic void add_token(input logic [3:0] kind,
                                     input logic [31:0] bo, input logic [23:0] br,
                                     input logic [15:0] bc, input logic [31:0] eo,
                                     input logic [23:0] er, input logic [15:0] ec);
      token_type t;
      t.kind = kind;
      t.begin_offset = bo;
      t.begin_row = br;
      t.begin_column = bc;
      t.end_offset = eo;
      t.end_row = er;
      t.end_column = ec;
      t.last = 1'b0;
      if (step_tokens.size() < 2) step_tokens.push_back(t);
   endfunction

   function automatic void token_here(input logic [3:0] kind);
      add_token(kind, at_offset, at_row, at_column, at_offset, at_row, at_column);
   endfunction

   function automatic void token_to_prior(input logic [3:0] kind);
      add_token(kind, tok_offset, tok_row, tok_column, prior_offset, prior_row, prior_column);
   endfunction

   function automatic void glyph_fault();
      add_token(K_BAD, tok_offset, tok_row, tok_column, tok_offset, tok_row, tok_column);
      stopped = 1'b1;
      mode = SCAN_GAP;
   endfunction

   function automatic void begin_token(input scan_mode_type m);
      mode = m;
      tok_offset = at_offset;
      tok_row = at_row;
      tok_column = at_column;
   endfunction

   function automatic void scan_gap(input logic [7:0] c);
      mode = SCAN_GAP;
      matched = 0;
      if (c == CHAR_NUL) begin
         token_here(K_EOF);
         stopped = 1'b1;
      end else if (is_blank(c)) begin
      end else if (c == CHAR_SEMI) begin
         token_here(K_SEMI);
      end else if (c == CHAR_OPEN) begin
         token_here(K_OPEN);
      end else if (c == CHAR_CLOSE) begin
         token_here(K_CLOSE);
      end else if (c == CHAR_T) begin
         begin_token(SCAN_TRUE);
         matched = 1;
      end else if (c == CHAR_F) begin
         begin_token(SCAN_FALSE);
         matched = 1;
      end else if (is_letter(c) || c == CHAR_UNDER) begin
         begin_token(SCAN_NAME);
      end else if (c == BYTE_E2) begin
         begin_token(SCAN_E2);
      end else if (c == BYTE_C2) begin
         begin_token(SCAN_C2);
      end else begin
         token_here(K_BAD);
         stopped = 1'b1;
      end
   endfunction

   function automatic void lex_byte(input logic [7:0] c);
      bit          is_t;
      int unsigned word_len;
      logic [3:0]  k;
      token_type   t;
      if (stopped) return;
      step_tokens.delete();
      case (mode)
         SCAN_NAME: begin
            if (!(is_word(c) || c == CHAR_UNDER)) begin
               token_to_prior(K_VAR);
               scan_gap(c);
            end
         end
         SCAN_TRUE, SCAN_FALSE: begin
            is_t = (mode == SCAN_TRUE);
            word_len = is_t ? 4 : 5;
            if (matched >= word_len) begin
               if (is_word(c)) begin
                  mode = SCAN_NAME;
                  matched = 0;
               end else begin
                  token_to_prior(is_t ? K_TRUE : K_FALSE);
                  scan_gap(c);
               end
            end else if (c == keyword_char(is_t, matched)) begin
               matched = matched + 1;
            end else if (is_word(c) || c == CHAR_UNDER) begin
               mode = SCAN_NAME;
               matched = 0;
            end else begin
               token_to_prior(K_VAR);
               scan_gap(c);
            end
         end
         SCAN_E2: begin
            if (c == BYTE_86 || c == BYTE_88 || c == BYTE_8A) begin
               glyph_mid = c;
               mode = SCAN_E2_MID;
            end else begin
               glyph_fault();
            end
         end
         SCAN_E2_MID: begin
            k = glyph_code(glyph_mid, c);
            glyph_mid = 8'h00;
            if (k == K_BAD) begin
               glyph_fault();
            end else begin
               add_token(k, tok_offset, tok_row, tok_column, at_offset, at_row, at_column);
               mode = SCAN_GAP;
            end
         end
         SCAN_C2: begin
            if (c == BYTE_AC) begin
               add_token(K_NOT, tok_offset, tok_row, tok_column, at_offset, at_row, at_column);
               mode = SCAN_GAP;
            end else begin
               glyph_fault();
            end
         end
         default: begin
            scan_gap(c);
         end
      endcase
      prior_offset = at_offset;
      prior_row = at_row;
      prior_column = at_column;
      if (at_offset != '1) at_offset = at_offset + 32'd1;
      if (!c[7] && at_column != '1) at_column = at_column + 16'd1;
      if (c == CHAR_LF) begin
         at_column = 16'd1;
         if (at_row != '1) at_row = at_row + 24'd1;
      end
      foreach (step_tokens[i]) begin
         t = step_tokens[i];
         t.last = (i == step_tokens.size() - 1);
         expected_tokens.push_back(t);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (tx_gaps && $urandom_range(0, 9) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      push <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (full) @(posedge clock);
      lex_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_glyph(input int idx);
      case (idx)
         0: begin send_byte(BYTE_E2); send_byte(BYTE_86); send_byte(BYTE_92); end
         1: begin send_byte(BYTE_E2); send_byte(BYTE_86); send_byte(BYTE_94); end
         2: begin send_byte(BYTE_E2); send_byte(BYTE_88); send_byte(BYTE_A7); end
         3: begin send_byte(BYTE_E2); send_byte(BYTE_88); send_byte(BYTE_A8); end
         4: begin send_byte(BYTE_E2); send_byte(BYTE_8A); send_byte(BYTE_BB); end
         default: begin send_byte(BYTE_C2); send_byte(BYTE_AC); end
      endcase
   endtask

   function automatic logic [7:0] name_char(input bit first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26) return 8'(8'h61 + r);
      if (r < 52) return 8'(8'h41 + r - 26);
      if (r == 52) return CHAR_UNDER;
      return 8'(8'h30 + r - 53);
   endfunction

   function automatic logic [7:0] blank_char();
      return BLANK_SET[8*$urandom_range(0, 5) +: 8];
   endfunction

   function automatic logic [7:0] tail_byte();
      return ($urandom_range(0, 3) == 0) ? CHAR_NUL : 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random_token();
      bit is_t;
      int cut;
      case ($urandom_range(0, 9))
         0: send_byte(PUNCT_SET[8*$urandom_range(0, 2) +: 8]);
         1, 8, 9: send_byte(blank_char());
         2, 3: begin
            send_byte(name_char(1'b1));
            repeat ($urandom_range(0, 7)) send_byte(name_char(1'b0));
         end
         4: begin
            is_t = 1'($urandom_range(0, 1));
            for (int i = 0; i < (is_t ? 4 : 5); i++) send_byte(keyword_char(is_t, i));
            if ($urandom_range(0, 3) == 0) send_byte(name_char(1'b0));
         end
         5: begin
            is_t = 1'($urandom_range(0, 1));
            cut = $urandom_range(1, is_t ? 3 : 4);
            for (int i = 0; i < cut; i++) send_byte(keyword_char(is_t, i));
            if ($urandom_range(0, 1) == 0) send_byte(name_char(1'b0));
            else send_byte(PUNCT_SET[8*$urandom_range(0, 2) +: 8]);
         end
         default: send_glyph($urandom_range(0, 5));
      endcase
   endtask

   task automatic test_directed_tokens();
      send_text("(true)");
      send_text("false_;");
      send_byte(8'h09);
      for (int g = 0; g < 6; g++) begin
         send_glyph(g);
         if (g == 1) send_byte(CHAR_LF);
      end
   endtask

   task automatic test_long_line();
      tx_gaps = 1'b0;
      send_byte(CHAR_LF);
      repeat (LONG_LINE_SPACES) send_byte(CHAR_SPACE);
      send_text("x;");
      send_glyph(5);
      send_byte(CHAR_LF);
      tx_gaps = 1'b1;
   endtask

   task automatic test_backpressure();
      tx_gaps = 1'b0;
      hold_request = 1'b1;
      repeat (120) send_text("ab;");
      if (hold_request) begin
         push <= 1'b0;
         wait (!hold_request);
         @(posedge clock);
      end
      tx_gaps = 1'b1;
   endtask

   task automatic test_random_formulas();
      int start;
      start = bytes_sent;
      for (int phase = 0; phase < 4; phase++) begin
         tx_gaps = (phase == 0 || phase == 1);
         rx_gaps = (phase == 0 || phase == 2);
         while (bytes_sent - start < 200 * (phase + 1)) send_random_token();
      end
   endtask

   task automatic test_halt_and_ignore();
      logic [7:0] c;
      logic [7:0] mid;
      case ($urandom_range(0, 4))
         0: send_byte(CHAR_NUL);
         1: begin
            do c = 8'($urandom_range(1, 255));
            while (is_blank(c) || is_letter(c) || c == CHAR_UNDER || c == CHAR_SEMI ||
                   c == CHAR_OPEN || c == CHAR_CLOSE || c == BYTE_E2 || c == BYTE_C2);
            send_byte(c);
         end
         2: begin
            send_byte(BYTE_E2);
            do c = tail_byte();
            while (c == BYTE_86 || c == BYTE_88 || c == BYTE_8A);
            send_byte(c);
         end
         3: begin
            send_byte(BYTE_E2);
            mid = GLYPH_MID_SET[8*$urandom_range(0, 2) +: 8];
            send_byte(mid);
            do c = tail_byte();
            while (glyph_code(mid, c) != K_BAD);
            send_byte(c);
         end
         default: begin
            send_byte(BYTE_C2);
            do c = tail_byte();
            while (c == BYTE_AC);
            send_byte(c);
         end
      endcase
      repeat (24) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_request = 1'b0;
         end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(0, 15)) @(posedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (!reset && pop && !empty) begin
         got.kind = rsp_token_kind;
         got.begin_offset = rsp_begin_offset;
         got.end_offset = rsp_end_offset;
         got.begin_row = rsp_begin_row;
         got.begin_column = rsp_begin_column;
         got.end_row = rsp_end_row;
         got.end_column = rsp_end_column;
         got.last = rsp_last_of_run;
         tokens_checked++;
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("unexpected token: %s", token_text(got));
         end else begin
            want = expected_tokens.pop_front();
            if (got.kind !== want.kind || got.begin_offset !== want.begin_offset ||
                got.end_offset !== want.end_offset || got.begin_row !== want.begin_row ||
                got.begin_column !== want.begin_column || got.end_row !== want.end_row ||
                got.end_column !== want.end_column || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("token %0d mismatch: expected %s", tokens_checked, token_text(want));
                  $display("   actual %s", token_text(got));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d tokens outstanding",
                  cycle_count, expected_tokens.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_tokens();
      test_long_line();
      test_backpressure();
      test_random_formulas();
      test_halt_and_ignore();
      push <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Scanned %0d bytes: punctuation, names, keywords, six glyphs, blanks,",
               bytes_sent);
      $display("a long line, a long output hold-off and a stop; %0d tokens, %0d bad.",
               tokens_checked, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
